[rtl/snl_pkg.sv]
// ----------------------------------------------------------------------------
// snl_pkg
// Shared widths, register indexes, reset values, phase codes and the sample
// record that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package snl_pkg;

	localparam int ADDR_W     = 32;
	localparam int HOLD_W     = 16;
	localparam int NIB_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_BASE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ADDRESS = 2'd2;

	// Register values after reset
	localparam logic [HOLD_W-1:0] HOLD_RESET  = 16'd1000;
	localparam logic [ADDR_W-1:0] BASE_RESET  = 32'h2000_0000;
	localparam logic [ADDR_W-1:0] ENTRY_RESET = 32'h2000_0001;

	// Loader phases
	localparam logic [1:0] PH_WAIT_HIGH = 2'd0;
	localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
	localparam logic [1:0] PH_EXEC_HOLD = 2'd2;
	localparam logic [1:0] PH_HALTED    = 2'd3;

	// One pin sample
	typedef struct packed {
		logic             strobe;
		logic             exec;
		logic [NIB_W-1:0] nib;
	} item_t;

endpackage

[rtl/snl_front.sv]
// ----------------------------------------------------------------------------
// snl_front
// Input stage: accepts pin samples, registers them as sample records and
// hands them to the queue when it has room.
// ----------------------------------------------------------------------------
module snl_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     strobe_req,
	input  logic                     exec_line,
	input  logic [snl_pkg::NIB_W-1:0] nibble,
	output logic                     push,
	output snl_pkg::item_t           push_item,
	input  logic                     q_ready
);
	import snl_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// Take a new sample when the stage is empty or drains this cycle
	assign in_ready  = !valid_s1 || q_ready;
	assign push      = valid_s1 && q_ready;
	assign push_item = item_s1;

	// Hold the valid flag for the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Pack the pin levels into a sample record
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.strobe <= strobe_req;
			item_s1.exec   <= exec_line;
			item_s1.nib    <= nibble;
		end
	end

endmodule

[rtl/snl_queue.sv]
// ----------------------------------------------------------------------------
// snl_queue
// Two-entry queue between front end and back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module snl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  snl_pkg::item_t push_item,
	output logic           q_ready,
	output logic           q_valid,
	output snl_pkg::item_t q_item,
	input  logic           pop
);
	import snl_pkg::*;

	item_t      mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready = (count_q != 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_item  = mem[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Fill level never goes past two entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue fill level out of range");

	// Pointers differ exactly when the queue holds one entry
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with fill level");

	// A pop from an empty queue never happens
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != 2'd0))
		else $error("queue popped while empty");

endmodule

[rtl/snl_back.sv]
// ----------------------------------------------------------------------------
// snl_back
// Loader state machine: qualifies strobe and execute runs, pairs nibbles
// into bytes, holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
module snl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  snl_pkg::item_t                q_item,
	output logic                          pop,
	input  logic                          cfg_write,
	input  logic [snl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          write_valid,
	output logic [snl_pkg::ADDR_W-1:0]     write_address,
	output logic [snl_pkg::BYTE_W-1:0]     write_byte,
	output logic                          led_on,
	output logic                          exec_request,
	output logic [snl_pkg::ADDR_W-1:0]     exec_target
);
	import snl_pkg::*;

	// Configuration
	logic [HOLD_W-1:0] hold_q;
	logic [ADDR_W-1:0] entry_q;

	// Loader state
	logic [1:0]        phase_q;
	logic [HOLD_W-1:0] run_q;
	logic [NIB_W-1:0]  low_q;
	logic              high_q;
	logic [ADDR_W-1:0] addr_q;
	logic              led_q;

	// Next state and result of the current sample
	logic [1:0]        phase_n;
	logic [HOLD_W-1:0] run_n;
	logic [NIB_W-1:0]  low_n;
	logic              high_n;
	logic [ADDR_W-1:0] addr_n;
	logic              led_n;
	logic [HOLD_W-1:0] run_inc;
	logic              qualified;
	logic              wv;
	logic [ADDR_W-1:0] wa;
	logic [BYTE_W-1:0] wb;
	logic              er;
	logic [ADDR_W-1:0] et;

	// Result register
	logic              out_valid_q;
	logic              wv_q;
	logic [ADDR_W-1:0] wa_q;
	logic [BYTE_W-1:0] wb_q;
	logic              led_out_q;
	logic              er_q;
	logic [ADDR_W-1:0] et_q;

	// Take the queue head when the result register is free or drains
	assign pop = q_valid && (!out_valid_q || out_ready);

	assign run_inc   = run_q + {{(HOLD_W-1){1'b0}}, 1'b1};
	assign qualified = (run_inc >= hold_q);

	// Step the loader by one sample
	always_comb begin
		phase_n = phase_q;
		run_n   = run_q;
		low_n   = low_q;
		high_n  = high_q;
		addr_n  = addr_q;
		led_n   = led_q;
		wv      = 1'b0;
		wa      = '0;
		wb      = '0;
		er      = 1'b0;
		et      = '0;
		case (phase_q)
			PH_WAIT_HIGH: begin
				if (!q_item.strobe) begin
					run_n = '0;
				end else if (qualified) begin
					run_n = '0;
					led_n = 1'b1;
					if (!high_q) begin
						low_n = q_item.nib;
					end else begin
						wv     = 1'b1;
						wa     = addr_q;
						wb     = {q_item.nib, low_q};
						addr_n = addr_q + {{(ADDR_W-1){1'b0}}, 1'b1};
						low_n  = '0;
					end
					high_n  = ~high_q;
					phase_n = PH_WAIT_LOW;
				end else begin
					run_n = run_inc;
				end
			end
			PH_WAIT_LOW: begin
				if (q_item.strobe) begin
					run_n = '0;
				end else if (qualified) begin
					run_n = '0;
					if (q_item.exec) begin
						phase_n = PH_EXEC_HOLD;
					end else begin
						led_n   = 1'b0;
						phase_n = PH_WAIT_HIGH;
					end
				end else begin
					run_n = run_inc;
				end
			end
			PH_EXEC_HOLD: begin
				if (!q_item.exec) begin
					run_n   = '0;
					led_n   = 1'b0;
					phase_n = PH_WAIT_HIGH;
				end else if (qualified) begin
					run_n   = '0;
					er      = 1'b1;
					et      = entry_q;
					phase_n = PH_HALTED;
				end else begin
					run_n = run_inc;
				end
			end
			PH_HALTED: begin
				// ignore every sample
			end
			default: begin
				phase_n = PH_WAIT_HIGH;
			end
		endcase
	end

	// Update configuration and loader state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			entry_q <= ENTRY_RESET;
			phase_q <= PH_WAIT_HIGH;
			run_q   <= '0;
			low_q   <= '0;
			high_q  <= 1'b0;
			addr_q  <= BASE_RESET;
			led_q   <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HOLD_SAMPLES:  hold_q  <= cfg_data[HOLD_W-1:0];
				REG_LOAD_BASE:     addr_q  <= cfg_data[ADDR_W-1:0];
				REG_ENTRY_ADDRESS: entry_q <= cfg_data[ADDR_W-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end else if (pop) begin
			phase_q <= phase_n;
			run_q   <= run_n;
			low_q   <= low_n;
			high_q  <= high_n;
			addr_q  <= addr_n;
			led_q   <= led_n;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wv_q      <= wv;
			wa_q      <= wa;
			wb_q      <= wb;
			led_out_q <= led_n;
			er_q      <= er;
			et_q      <= et;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_valid   = wv_q;
	assign write_address = wa_q;
	assign write_byte    = wb_q;
	assign led_on        = led_out_q;
	assign exec_request  = er_q;
	assign exec_target   = et_q;

	// Once halted the loader stays halted
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HALTED) |=> (phase_q == PH_HALTED))
		else $error("loader left the halted phase");

	// A byte write always comes with the LED on
	a_write_led: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wv_q) |-> led_out_q)
		else $error("byte written with LED off");

	// An execute request leaves the loader halted with the LED on
	a_exec_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && er) |=> (phase_q == PH_HALTED) && led_q)
		else $error("execute request did not halt the loader");

endmodule

[rtl/strobed_nibble_loader.sv]
// ----------------------------------------------------------------------------
// strobed_nibble_loader
// Pin-sampling loader. One pin sample per input transaction (strobe, execute,
// nibble); one result transaction per sample with the byte write, LED level
// and execute request that the sample causes.
//
// Channels: input in_valid/in_ready with strobe_req, exec_line, nibble;
// output out_valid/out_ready with write_valid, write_address, write_byte,
// led_on, exec_request, exec_target. Configuration is a plain write port
// (cfg_write, cfg_index, cfg_data): 0 hold_samples, 1 load_base (also
// reloads the write address), 2 entry_address. Write it only while idle.
// Throughput: one sample per cycle while out_ready stays high, set by the
// loader state machine in the back end. Path: a sample passes through the
// input register, a queue entry and the result register, in that order.
// A two-entry queue sits between front and back end.
// Reset: registers return to their defaults, the loader waits for a strobe
// rise, nothing is held. When the receiver stalls the result register holds
// its transaction; the queue and input register absorb three more samples
// before in_ready drops.
// ----------------------------------------------------------------------------
module strobed_nibble_loader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          strobe_req,
	input  logic                          exec_line,
	input  logic [snl_pkg::NIB_W-1:0]      nibble,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          write_valid,
	output logic [snl_pkg::ADDR_W-1:0]     write_address,
	output logic [snl_pkg::BYTE_W-1:0]     write_byte,
	output logic                          led_on,
	output logic                          exec_request,
	output logic [snl_pkg::ADDR_W-1:0]     exec_target,
	input  logic                          cfg_write,
	input  logic [snl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [snl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import snl_pkg::*;

	logic  push;
	item_t push_item;
	logic  q_ready;
	logic  q_valid;
	item_t q_item;
	logic  pop;

	// Accept and register samples
	snl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.strobe_req (strobe_req),
		.exec_line  (exec_line),
		.nibble     (nibble),
		.push       (push),
		.push_item  (push_item),
		.q_ready    (q_ready)
	);

	// Decouple front and back end
	snl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	// Run the loader and present results
	snl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.pop           (pop),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_valid   (write_valid),
		.write_address (write_address),
		.write_byte    (write_byte),
		.led_on        (led_on),
		.exec_request  (exec_request),
		.exec_target   (exec_target)
	);

endmodule
